[sv/viterbi_hard_decoder_4state_defines.svh]
// assertion macros used by the decoder back end
`ifndef VITERBI_HARD_DECODER_4STATE_DEFINES_SVH
`define VITERBI_HARD_DECODER_4STATE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define VHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define VHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/vhd_pkg.sv]
package vhd_pkg;

    // sizing defaults
    localparam int MAX_BITS_DEF = 64;
    localparam int NUM_STATES   = 4;
    localparam int QDEPTH       = 2;

    // register and metric constants
    localparam logic [23:0] RESET_CODEWORDS = 24'h74F8B0;
    localparam logic [7:0]  METRIC_MAX      = 8'hFF;

    // input transaction
    typedef struct packed {
        logic [15:0] prob0_bit0;
        logic [15:0] prob1_bit0;
        logic [15:0] prob0_bit1;
        logic [15:0] prob1_bit1;
        logic [15:0] prob0_bit2;
        logic [15:0] prob1_bit2;
        logic        last_step;
    } in_t;

    // result transaction
    typedef struct packed {
        logic [63:0] decoded_bits;
        logic [6:0]  bit_count;
        logic [7:0]  best_metric;
    } out_t;

    // sliced trellis step
    typedef struct packed {
        logic [2:0] rx;
        logic       last;
    } sym_t;

    // head of the step queue
    typedef struct packed {
        logic valid;
        sym_t sym;
    } q_head_t;

    // hamming weight of a 3-bit word
    function automatic logic [1:0] hamming3(input logic [2:0] x);
        return {1'b0, x[0]} + {1'b0, x[1]} + {1'b0, x[2]};
    endfunction

    // metric add saturating at the unreachable mark
    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {7'd0, b};
        return s[8] ? METRIC_MAX : s[7:0];
    endfunction

endpackage

[sv/vhd_front.sv]
module vhd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  vhd_pkg::in_t     s_data,
    output vhd_pkg::q_head_t head,
    input  logic             pop
);

    localparam int PtrW = (vhd_pkg::QDEPTH > 1) ? $clog2(vhd_pkg::QDEPTH) : 1;
    localparam int CntW = $clog2(vhd_pkg::QDEPTH + 1);

    vhd_pkg::sym_t      q_reg [vhd_pkg::QDEPTH];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    vhd_pkg::sym_t      sym;
    logic               push;

    // slice each likelihood pair to a hard bit
    always_comb begin
        sym.rx[0] = s_data.prob1_bit0 > s_data.prob0_bit0;
        sym.rx[1] = s_data.prob1_bit1 > s_data.prob0_bit1;
        sym.rx[2] = s_data.prob1_bit2 > s_data.prob0_bit2;
        sym.last  = s_data.last_step;
    end

    assign s_ready = (cnt_reg != CntW'(vhd_pkg::QDEPTH));
    assign push    = s_valid && s_ready;

    assign head.valid = (cnt_reg != '0);
    assign head.sym   = q_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(vhd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(vhd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= sym;
        end
    end

endmodule

[sv/vhd_back.sv]
`include "viterbi_hard_decoder_4state_defines.svh"

module vhd_back #(
    parameter int MAX_BITS = vhd_pkg::MAX_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [23:0]      cfg_wr_data,
    input  vhd_pkg::q_head_t head,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output vhd_pkg::out_t    m_data
);

    localparam int CntW = $clog2(MAX_BITS);
    localparam int NS   = vhd_pkg::NUM_STATES;

    logic [23:0]         cfg_reg;
    logic [7:0]          metric_reg [NS];
    logic [7:0]          metric_next [NS];
    logic [MAX_BITS-1:0] surv_reg [NS];
    logic [MAX_BITS-1:0] surv_next [NS];
    logic [CntW-1:0]     step_reg;
    logic                m_valid_reg, m_valid_next;
    vhd_pkg::out_t       out_reg;
    logic                end_blk;
    logic [MAX_BITS-1:0] pos_mask;
    logic [1:0]          b01, b23, best;

    // codeword register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= vhd_pkg::RESET_CODEWORDS;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    assign end_blk  = head.sym.last || (step_reg == CntW'(MAX_BITS - 1));
    assign pop      = head.valid && (!end_blk || !m_valid_reg || m_ready);
    assign pos_mask = {{(MAX_BITS-1){1'b0}}, 1'b1} << step_reg;

    // four add-compare-select units
    always_comb begin
        logic [2:0] cw0, cw1;
        logic [7:0] m0, m1;
        int unsigned p0;
        for (int s = 0; s < NS; s++) begin
            p0  = (s % 2 == 1) ? 2 : 0;
            cw0 = cfg_reg[3*(2*s) +: 3];
            cw1 = cfg_reg[3*(2*s+1) +: 3];
            m0  = vhd_pkg::sat_add(metric_reg[p0], vhd_pkg::hamming3(head.sym.rx ^ cw0));
            m1  = vhd_pkg::sat_add(metric_reg[p0+1], vhd_pkg::hamming3(head.sym.rx ^ cw1));
            if (m0 <= m1) begin
                metric_next[s] = m0;
                surv_next[s]   = surv_reg[p0];
            end else begin
                metric_next[s] = m1;
                surv_next[s]   = surv_reg[p0+1];
            end
            if (s >= 2) begin
                surv_next[s] = surv_next[s] | pos_mask;
            end
        end
    end

    // lowest metric state, ties to the lower state
    always_comb begin
        b01  = (metric_next[1] < metric_next[0]) ? 2'd1 : 2'd0;
        b23  = (metric_next[3] < metric_next[2]) ? 2'd3 : 2'd2;
        best = (metric_next[b23] < metric_next[b01]) ? b23 : b01;
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || (pop && end_blk);

    // trellis state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NS; s++) begin
                metric_reg[s] <= (s == 0) ? 8'd0 : vhd_pkg::METRIC_MAX;
                surv_reg[s]   <= '0;
            end
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                if (end_blk) begin
                    for (int s = 0; s < NS; s++) begin
                        metric_reg[s] <= (s == 0) ? 8'd0 : vhd_pkg::METRIC_MAX;
                        surv_reg[s]   <= '0;
                    end
                    step_reg <= '0;
                end else begin
                    for (int s = 0; s < NS; s++) begin
                        metric_reg[s] <= metric_next[s];
                        surv_reg[s]   <= surv_next[s];
                    end
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (pop && end_blk) begin
            out_reg.decoded_bits <= 64'(surv_next[best]);
            out_reg.bit_count    <= 7'(step_reg) + 7'd1;
            out_reg.best_metric  <= metric_next[best];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `VHD_ASSERT_NEXT(a_emit_sets_valid, aclk, aresetn, pop && end_blk, m_valid_reg, "block end did not raise result valid")
    `VHD_ASSERT_NEXT(a_emit_restarts, aclk, aresetn, pop && end_blk, (step_reg == '0) && (metric_reg[0] == 8'd0), "trellis not restarted after block end")
    `VHD_ASSERT_NOW(a_no_overwrite, aclk, aresetn, m_valid_reg && !m_ready, !(pop && end_blk), "pending result overwritten")
    `VHD_ASSERT_NOW(a_count_range, aclk, aresetn, m_valid_reg, (out_reg.bit_count != 7'd0) && (out_reg.bit_count <= 7'(MAX_BITS)), "bit count out of range")

endmodule

[sv/viterbi_hard_decoder_4state.sv]
// path: sliced steps wait in the step queue; a pop feeds the trellis and result registers
// throughput: one trellis step per cycle, set by the four parallel add-compare-select units,
// but a block end waits on a pending result; the front slicer and two-entry queue absorb it
// reset: aresetn synchronous active low; codewords return to 0x74F8B0, trellis to state 0
// no clearing pass; the block accepts transactions in the first cycle after reset
module viterbi_hard_decoder_4state #(
    parameter int MAX_BITS = vhd_pkg::MAX_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [23:0]   cfg_wr_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  vhd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output vhd_pkg::out_t m_data
);

    vhd_pkg::q_head_t head;
    logic             pop;

    // slicer and step queue
    vhd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .head    (head),
        .pop     (pop)
    );

    // add-compare-select and result register
    vhd_back #(
        .MAX_BITS (MAX_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[tb/sv/viterbi_hard_decoder_4state_checker.sv]
`timescale 1ns / 100ps

module viterbi_hard_decoder_4state_checker #(
    parameter int MAX_BITS = vhd_pkg::MAX_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [23:0]   cfg_wr_data,
    input  logic          s_valid,
    input  logic          s_ready,
    input  vhd_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  vhd_pkg::out_t m_data,
    output int            outstanding,
    output int            fail_count
);

    // trellis copy kept by the checker
    logic [23:0] codewords;
    logic [7:0]  metric [4];
    logic [63:0] survivor [4];
    logic [6:0]  step_idx;

    // decoded blocks waiting for their result transaction
    vhd_pkg::out_t decoded_blocks [$];
    vhd_pkg::out_t want;
    int            errors = 0;

    // branch distance added to a path metric, pinned at the unreachable mark
    function automatic logic [7:0] metric_add(input logic [7:0] m, input logic [2:0] diff);
        logic [8:0] sum;
        sum = {1'b0, m} + diff[0] + diff[1] + diff[2];
        return (sum > 9'd255) ? 8'hFF : sum[7:0];
    endfunction

    // back to the start of a block: only state 0 reachable
    task automatic restart_trellis();
        for (int s = 0; s < 4; s++) begin
            metric[s]   = (s == 0) ? 8'd0 : 8'hFF;
            survivor[s] = '0;
        end
        step_idx = '0;
    endtask

    // one add-compare-select step; closes the block on last_step or a full block
    task automatic decode_step(input vhd_pkg::in_t item);
        logic [2:0]    rx;
        logic [7:0]    nm [4];
        logic [63:0]   nsurv [4];
        logic [7:0]    m0, m1;
        logic [2:0]    cw0, cw1;
        logic [5:0]    pos;
        int            pred0, pick, best;
        vhd_pkg::out_t blk;
        rx[0] = item.prob1_bit0 > item.prob0_bit0;
        rx[1] = item.prob1_bit1 > item.prob0_bit1;
        rx[2] = item.prob1_bit2 > item.prob0_bit2;
        pos   = step_idx[5:0];
        for (int s = 0; s < 4; s++) begin
            pred0 = (s % 2 == 1) ? 2 : 0;
            cw0   = codewords[3 * (s * 2) +: 3];
            cw1   = codewords[3 * (s * 2 + 1) +: 3];
            m0    = metric_add(metric[pred0], rx ^ cw0);
            m1    = metric_add(metric[pred0 + 1], rx ^ cw1);
            // ties go to the lower predecessor
            pick     = (m0 <= m1) ? pred0 : pred0 + 1;
            nm[s]    = (m0 <= m1) ? m0 : m1;
            nsurv[s] = survivor[pick];
            if (s >= 2) begin
                nsurv[s][pos] = 1'b1;
            end
        end
        for (int s = 0; s < 4; s++) begin
            metric[s]   = nm[s];
            survivor[s] = nsurv[s];
        end
        if (item.last_step || (int'(step_idx) + 1 >= MAX_BITS)) begin
            // lowest metric wins, lowest state on a tie
            best = 0;
            for (int s = 1; s < 4; s++) begin
                if (metric[s] < metric[best]) begin
                    best = s;
                end
            end
            blk.decoded_bits = survivor[best];
            blk.bit_count    = step_idx + 7'd1;
            blk.best_metric  = metric[best];
            decoded_blocks.push_back(blk);
            restart_trellis();
        end else begin
            step_idx = step_idx + 7'd1;
        end
    endtask

    // watch both channels at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            codewords = vhd_pkg::RESET_CODEWORDS;
            restart_trellis();
            decoded_blocks.delete();
        end else begin
            // compare the result against the oldest decoded block
            if (m_valid && m_ready) begin
                if (decoded_blocks.size() == 0) begin
                    errors++;
                    $error("unexpected result: decoded_bits %h bit_count %0d best_metric %0d",
                           m_data.decoded_bits, m_data.bit_count, m_data.best_metric);
                end else begin
                    want = decoded_blocks.pop_front();
                    if (m_data.decoded_bits !== want.decoded_bits) begin
                        errors++;
                        $error("decoded_bits expected %h actual %h",
                               want.decoded_bits, m_data.decoded_bits);
                    end
                    if (m_data.bit_count !== want.bit_count) begin
                        errors++;
                        $error("bit_count expected %0d actual %0d",
                               want.bit_count, m_data.bit_count);
                    end
                    if (m_data.best_metric !== want.best_metric) begin
                        errors++;
                        $error("best_metric expected %0d actual %0d",
                               want.best_metric, m_data.best_metric);
                    end
                end
            end
            if (cfg_wr_en) begin
                codewords = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                decode_step(s_data);
            end
        end
        outstanding <= decoded_blocks.size();
        fail_count  <= errors;
    end

endmodule

[tb/sv/viterbi_hard_decoder_4state_tb.sv]
`timescale 1ns / 100ps

module viterbi_hard_decoder_4state_tb;

    localparam int RESET_CYCLES   = 3;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 225;

    logic          aclk        = 1'b0;
    logic          aresetn     = 1'b0;
    logic          cfg_wr_en   = 1'b0;
    logic [23:0]   cfg_wr_data = '0;
    logic          s_valid     = 1'b0;
    logic          s_ready;
    vhd_pkg::in_t  s_data      = '0;
    logic          m_valid;
    logic          m_ready     = 1'b0;
    vhd_pkg::out_t m_data;

    int          outstanding;
    int          fail_count;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    int          quiet_cycles   = 0;
    int          phase_start;
    logic [23:0] active_codewords = vhd_pkg::RESET_CODEWORDS;
    logic [23:0] phase_codewords [NUM_PHASES];

    always #5 aclk = ~aclk;

    viterbi_hard_decoder_4state u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    viterbi_hard_decoder_4state_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // result port back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // cycles without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    // likelihood pair {zero, one} that slices to the given coded bit
    function automatic logic [31:0] likelihood_pair(input logic bit_val);
        logic [15:0] lo, hi;
        lo = 16'($urandom_range(0, 65534));
        hi = 16'($urandom_range(lo + 1, 65535));
        if (bit_val) begin
            return {lo, hi};
        end else if ($urandom_range(0, 7) == 0) begin
            // equal likelihoods slice to zero
            return {hi, hi};
        end else begin
            return {hi, lo};
        end
    endfunction

    function automatic vhd_pkg::in_t make_step(input logic [2:0] coded, input logic last);
        vhd_pkg::in_t item;
        logic [31:0]  pr;
        pr = likelihood_pair(coded[0]);
        item.prob0_bit0 = pr[31:16];
        item.prob1_bit0 = pr[15:0];
        pr = likelihood_pair(coded[1]);
        item.prob0_bit1 = pr[31:16];
        item.prob1_bit1 = pr[15:0];
        pr = likelihood_pair(coded[2]);
        item.prob0_bit2 = pr[31:16];
        item.prob1_bit2 = pr[15:0];
        item.last_step  = last;
        return item;
    endfunction

    function automatic vhd_pkg::in_t uniform_step(input logic [15:0] p0, input logic [15:0] p1,
                                                  input logic last);
        vhd_pkg::in_t item;
        item.prob0_bit0 = p0;
        item.prob1_bit0 = p1;
        item.prob0_bit1 = p0;
        item.prob1_bit1 = p1;
        item.prob0_bit2 = p0;
        item.prob1_bit2 = p1;
        item.last_step  = last;
        return item;
    endfunction

    // present one input transaction and hold it until accepted
    task automatic send_item(input vhd_pkg::in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // encode random information bits with the current codewords, then flip some
    task automatic send_encoded_block(input int len, input bit leave_open, input int flip_pct);
        logic [1:0] enc_state, next_state;
        logic [2:0] coded;
        logic       info, last;
        int         idx;
        enc_state = 2'd0;
        for (int i = 0; i < len; i++) begin
            info       = 1'($urandom_range(0, 1));
            next_state = enc_state[1] ? (info ? 2'd3 : 2'd1) : (info ? 2'd2 : 2'd0);
            idx        = (int'(next_state) * 2 + int'(enc_state[0])) * 3;
            coded      = active_codewords[idx +: 3];
            for (int b = 0; b < 3; b++) begin
                if ($urandom_range(0, 99) < flip_pct) begin
                    coded[b] = ~coded[b];
                end
            end
            last = (i == len - 1) && !leave_open;
            send_item(make_step(coded, last));
            enc_state = next_state;
        end
    endtask

    // let the decoder empty out before touching the register or ending
    task automatic drain_decoder();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_codewords(input logic [23:0] value);
        drain_decoder();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        active_codewords = value;
    endtask

    // field extremes, ties, every sliced symbol, a clean and a noisy short block
    task automatic run_directed();
        send_item(uniform_step(16'h0000, 16'h0000, 1'b1));
        send_item(uniform_step(16'hFFFF, 16'hFFFF, 1'b1));
        send_item(uniform_step(16'h0000, 16'hFFFF, 1'b1));
        send_item(uniform_step(16'hFFFF, 16'h0000, 1'b1));
        send_item(uniform_step(16'hFFFE, 16'hFFFF, 1'b1));
        send_item(uniform_step(16'h7FFF, 16'h8000, 1'b0));
        send_item(uniform_step(16'h8000, 16'h7FFF, 1'b1));
        for (int c = 0; c < 8; c++) begin
            send_item(make_step(c[2:0], c == 7));
        end
        send_encoded_block(6, 1'b0, 0);
        send_encoded_block(4, 1'b0, 35);
    endtask

    // mostly well-formed blocks, some heavy noise, some raw items
    task automatic run_random_sequence();
        int pick, len;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = $urandom_range(0, 99);
            if (len < 82) begin
                len = $urandom_range(1, 16);
            end else if (len < 92) begin
                len = $urandom_range(17, 63);
            end else begin
                len = vhd_pkg::MAX_BITS_DEF;
            end
            send_encoded_block(len,
                               (len == vhd_pkg::MAX_BITS_DEF) && $urandom_range(0, 1),
                               5);
        end else if (pick < 85) begin
            send_encoded_block($urandom_range(1, 20), 1'b0, 40);
        end else begin
            send_item('{prob0_bit0: 16'($urandom_range(0, 65535)),
                        prob1_bit0: 16'($urandom_range(0, 65535)),
                        prob0_bit1: 16'($urandom_range(0, 65535)),
                        prob1_bit1: 16'($urandom_range(0, 65535)),
                        prob0_bit2: 16'($urandom_range(0, 65535)),
                        prob1_bit2: 16'($urandom_range(0, 65535)),
                        last_step:  ($urandom_range(0, 7) == 0)});
        end
    endtask

    // main sequence
    initial begin
        phase_codewords[0] = vhd_pkg::RESET_CODEWORDS;
        phase_codewords[1] = 24'h000000;
        phase_codewords[2] = 24'hFFFFFF;
        phase_codewords[3] = 24'($urandom_range(0, 24'hFFFFFF));
        phase_codewords[4] = 24'($urandom_range(0, 24'hFFFFFF));
        phase_codewords[5] = vhd_pkg::RESET_CODEWORDS;
        phase_codewords[6] = 24'($urandom_range(0, 24'hFFFFFF));
        phase_codewords[7] = 24'hFFFFFF;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                write_codewords(phase_codewords[phase]);
            end
            // idle pattern for this phase
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            if (phase == 0) begin
                run_directed();
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                run_random_sequence();
            end
        end

        drain_decoder();
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
